@@ hw/rtl/tsx_pkg.sv @@
// Shared constants, types and window-match functions of the TLS SNI extractor.
package tsx_pkg;

    localparam int MAX_FRAME_BYTES = 65536;
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    localparam int WIN_LEN = 21;
    localparam int IDX_W = $clog2(WIN_LEN);
    localparam int CNT_W = $clog2(WIN_LEN + 1);
    localparam int NAME_OFS = 9;
    localparam int NAME_BURST = WIN_LEN - NAME_OFS;
    localparam int BURST_W = $clog2(NAME_BURST + 1);
    localparam int QUEUE_LIMIT = WIN_LEN - 1;

    localparam int ETH_HDR_BYTES = 14;
    localparam int IHL_POS = 14;
    localparam int DEST_FIRST = 30;
    localparam int DEST_LAST = 33;
    localparam int DOFF_BASE = 26;
    localparam int MIN_HDR_WORDS = 5;
    localparam int MIN_TCP_BYTES = 20;
    localparam int HELLO_OFS = 5;
    localparam int SCAN_SPAN = 20;
    localparam int MIN_HEADER_BYTES = 14 + 20 + 20;
    localparam int MIN_PAYLOAD_SEEN = 6;
    localparam int PSTART_W = 8;

    localparam logic [7:0] TLS_HANDSHAKE = 8'h16;
    localparam logic [7:0] TLS_CLIENT_HELLO = 8'h01;
    localparam logic [7:0] IHL_MASK = 8'h0f;
    localparam logic [7:0] DOFF_MASK = 8'hf0;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_FOUND,
        PH_IGNORE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NAME   = 2'd0,
        KIND_FOUND  = 2'd1,
        KIND_NO_SNI = 2'd2
    } result_kind_t;

    // taps[k] is window byte k as it stands after the incoming byte shifts in
    typedef logic [8:0][7:0] win_taps_t;

    typedef struct packed {
        logic                 shift;
        logic                 match;
        logic [BURST_W-1:0]   burst;
        logic                 append;
        logic                 sum_valid;
        result_kind_t         sum_kind;
        logic [31:0]          sum_dest;
        logic [15:0]          sum_len;
        logic                 sum_trunc;
    } tsx_event_t;

    function automatic logic [15:0] sni_len(win_taps_t w);
        return {w[7], w[8]};
    endfunction

    function automatic logic sni_match(win_taps_t w);
        logic [16:0] l1;
        logic [16:0] l2;
        logic [16:0] l3;
        l1 = {1'b0, w[2], w[3]};
        l2 = {1'b0, w[4], w[5]};
        l3 = {1'b0, w[7], w[8]};
        return (w[0] == 8'd0) && (w[1] == 8'd0) && (w[2] <= 8'd1) && (w[6] == 8'd0)
            && (l1 == l2 + 17'd2) && (l1 == l3 + 17'd5);
    endfunction

endpackage

@@ hw/rtl/tsx_parser.sv @@
// Frame parser: header fields, ClientHello check, SNI window match and frame summary.
module tsx_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             data_byte,
    input  logic                   frame_end,
    input  tsx_pkg::win_taps_t     taps,
    output tsx_pkg::tsx_event_t    ev
);
    import tsx_pkg::*;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [5:0]          ip_hdr_reg, ip_hdr_next;
    logic [5:0]          tcp_hdr_reg, tcp_hdr_next;
    logic [PSTART_W-1:0] pstart_reg, pstart_next;
    logic [31:0]         dest_reg, dest_next;
    phase_t              phase_reg, phase_next;
    logic [15:0]         name_left_reg, name_left_next;
    logic [15:0]         decl_len_reg, decl_len_next;

    logic               live;
    logic [POS_W-1:0]   off;
    logic [POS_W-1:0]   pos_new;
    logic [7:0]         ihl_byte;
    logic [3:0]         ihl;
    logic [7:0]         doff_byte;
    logic [5:0]         th;
    logic               hdr_step, at_ihl, at_dest, at_doff, at_pay;
    logic               ihl_bad, doff_bad;
    phase_t             ph_hdr, ph_fin;
    logic               pay_step, hs_bad, ch_bad, hit, name_step;
    logic [15:0]        l3;
    logic [BURST_W-1:0] burst;
    logic [15:0]        name_left_new, decl_new;
    logic [31:0]        dest_new;
    logic               sum_nosni, sum_found;

    assign live      = pos_reg < POS_W'(MAX_FRAME_BYTES);
    assign off       = pos_reg - POS_W'(pstart_reg);
    assign pos_new   = live ? pos_reg + POS_W'(1) : pos_reg;
    assign ihl_byte  = data_byte & IHL_MASK;
    assign ihl       = ihl_byte[3:0];
    assign doff_byte = (data_byte & DOFF_MASK) >> 2;
    assign th        = doff_byte[5:0];
    assign ihl_bad   = ihl < 4'(MIN_HDR_WORDS);
    assign doff_bad  = th < 6'(MIN_TCP_BYTES);

    assign hdr_step = live && (phase_reg == PH_HEADER);
    assign at_ihl   = pos_reg == POS_W'(IHL_POS);
    assign at_dest  = (pos_reg >= POS_W'(DEST_FIRST)) && (pos_reg <= POS_W'(DEST_LAST));
    assign at_doff  = (pos_reg > POS_W'(IHL_POS))
                   && (pos_reg == POS_W'(DOFF_BASE) + POS_W'(ip_hdr_reg));
    assign at_pay   = (pstart_reg != '0) && (pos_reg >= POS_W'(pstart_reg));

    // phase after the header step of this byte
    always_comb
    begin
        ph_hdr = phase_reg;
        if (hdr_step)
        begin
            if (at_ihl)
            begin
                if (ihl_bad)
                    ph_hdr = PH_IGNORE;
            end
            else if (at_dest)
            begin
                ph_hdr = phase_reg;
            end
            else if (at_doff)
            begin
                if (doff_bad)
                    ph_hdr = PH_IGNORE;
            end
            else if (at_pay)
            begin
                ph_hdr = PH_PAYLOAD;
            end
        end
    end

    assign pay_step  = live && (ph_hdr == PH_PAYLOAD);
    assign hs_bad    = (off == '0) && (data_byte != TLS_HANDSHAKE);
    assign ch_bad    = (off == POS_W'(HELLO_OFS)) && (data_byte != TLS_CLIENT_HELLO);
    assign hit       = (off >= POS_W'(SCAN_SPAN)) && sni_match(taps);
    assign name_step = live && (ph_hdr == PH_FOUND) && (name_left_reg != 16'd0);
    assign l3        = sni_len(taps);
    assign burst     = (l3 < 16'(NAME_BURST)) ? l3[BURST_W-1:0] : BURST_W'(NAME_BURST);

    always_comb
    begin
        ph_fin = ph_hdr;
        if (pay_step)
        begin
            if (hs_bad || ch_bad)
                ph_fin = PH_IGNORE;
            else if (hit)
                ph_fin = PH_FOUND;
        end
    end

    assign name_left_new = (pay_step && hit) ? l3 - 16'(burst)
                         : name_step ? name_left_reg - 16'd1 : name_left_reg;
    assign decl_new      = (pay_step && hit) ? l3 : decl_len_reg;
    assign dest_new      = (hdr_step && !at_ihl && at_dest) ? {dest_reg[23:0], data_byte}
                                                            : dest_reg;
    assign sum_nosni = (ph_fin == PH_PAYLOAD) && (pos_new >= POS_W'(MIN_HEADER_BYTES))
                    && ((pos_new - POS_W'(pstart_reg)) >= POS_W'(MIN_PAYLOAD_SEEN));
    assign sum_found = ph_fin == PH_FOUND;

    // next state
    always_comb
    begin
        pos_next       = pos_reg;
        ip_hdr_next    = ip_hdr_reg;
        tcp_hdr_next   = tcp_hdr_reg;
        pstart_next    = pstart_reg;
        dest_next      = dest_reg;
        phase_next     = phase_reg;
        name_left_next = name_left_reg;
        decl_len_next  = decl_len_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                pos_next       = '0;
                ip_hdr_next    = '0;
                tcp_hdr_next   = '0;
                pstart_next    = '0;
                dest_next      = '0;
                phase_next     = PH_HEADER;
                name_left_next = '0;
                decl_len_next  = '0;
            end
            else
            begin
                pos_next       = pos_new;
                phase_next     = ph_fin;
                dest_next      = dest_new;
                name_left_next = name_left_new;
                decl_len_next  = decl_new;
                if (hdr_step && at_ihl && !ihl_bad)
                    ip_hdr_next = {ihl, 2'b00};
                if (hdr_step && !at_ihl && !at_dest && at_doff && !doff_bad)
                begin
                    tcp_hdr_next = th;
                    pstart_next  = PSTART_W'(ETH_HDR_BYTES) + PSTART_W'(ip_hdr_reg)
                                 + PSTART_W'(th);
                end
            end
        end
    end

    // events toward the name queue
    always_comb
    begin
        ev           = '0;
        ev.shift     = accept && (pay_step || name_step);
        ev.match     = accept && pay_step && hit;
        ev.burst     = burst;
        ev.append    = accept && name_step;
        ev.sum_valid = accept && frame_end && (sum_nosni || sum_found);
        ev.sum_kind  = sum_found ? KIND_FOUND : KIND_NO_SNI;
        ev.sum_dest  = dest_new;
        ev.sum_len   = sum_found ? decl_new : 16'd0;
        ev.sum_trunc = sum_found && (name_left_new != 16'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ip_hdr_reg    <= '0;
            tcp_hdr_reg   <= '0;
            pstart_reg    <= '0;
            dest_reg      <= '0;
            phase_reg     <= PH_HEADER;
            name_left_reg <= '0;
            decl_len_reg  <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            ip_hdr_reg    <= ip_hdr_next;
            tcp_hdr_reg   <= tcp_hdr_next;
            pstart_reg    <= pstart_next;
            dest_reg      <= dest_next;
            phase_reg     <= phase_next;
            name_left_reg <= name_left_next;
            decl_len_reg  <= decl_len_next;
        end
    end

`ifndef SYNTHESIS
    a_tcp_len_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (pstart_reg != '0) |-> (tcp_hdr_reg >= 6'(MIN_TCP_BYTES)))
        else $error("payload start set with short TCP header");
    a_found_has_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FOUND) |-> (name_left_reg <= decl_len_reg))
        else $error("names left exceed declared length");
    a_payload_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_PAYLOAD) || (phase_reg == PH_FOUND))
            |-> (pstart_reg >= PSTART_W'(MIN_HEADER_BYTES)))
        else $error("payload phase without a valid payload start");
`endif

endmodule

@@ hw/rtl/tsx_queue.sv @@
// Byte window, name queue, pending summary and result register.
module tsx_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             data_byte,
    input  tsx_pkg::tsx_event_t    ev,
    output tsx_pkg::win_taps_t     taps,
    output logic                   in_stall,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [1:0]             result_kind,
    output logic [7:0]             name_byte,
    output logic [31:0]            dest_address,
    output logic [15:0]            name_length,
    output logic                   name_truncated,
    output logic                   last_of_run
);
    import tsx_pkg::*;

    logic [7:0]         win_reg [WIN_LEN];
    logic [7:0]         win_next [WIN_LEN];
    logic [WIN_LEN-1:0] last_reg, last_next;
    logic [CNT_W-1:0]   nq_reg, nq_next;
    logic [IDX_W-1:0]   rd_reg, rd_next;

    logic               sum_pend_reg, sum_pend_next;
    result_kind_t       sum_kind_reg;
    logic [31:0]        sum_dest_reg;
    logic [15:0]        sum_len_reg;
    logic               sum_trunc_reg;

    logic               valid_reg, valid_next;
    result_kind_t       kind_reg;
    logic [7:0]         byte_reg;
    logic [31:0]        dest_reg;
    logic [15:0]        len_reg;
    logic               trunc_reg;
    logic               last_out_reg;

    logic               out_load, have_name, pop_name, pop_sum;
    logic [7:0]         name_sel;
    logic               last_sel;

    always_comb
    begin
        for (int k = 0; k < NAME_OFS; k++)
            taps[k] = win_reg[k + 1];
    end

    assign in_stall  = sum_pend_reg || (nq_reg >= CNT_W'(QUEUE_LIMIT));
    assign out_load  = !valid_reg || !result_stall;
    assign have_name = nq_reg != '0;
    assign pop_name  = out_load && have_name;
    assign pop_sum   = out_load && !have_name && sum_pend_reg;
    assign name_sel  = win_reg[rd_reg];
    assign last_sel  = last_reg[rd_reg];

    always_comb
    begin
        win_next  = win_reg;
        last_next = last_reg;
        nq_next   = nq_reg;
        rd_next   = rd_reg;
        if (ev.shift)
        begin
            for (int k = 0; k < WIN_LEN - 1; k++)
            begin
                win_next[k]  = win_reg[k + 1];
                last_next[k] = last_reg[k + 1];
            end
            win_next[WIN_LEN-1]  = data_byte;
            last_next[WIN_LEN-1] = !ev.sum_valid;
        end
        if (ev.match)
        begin
            // mark the end of the burst taken straight from the window
            for (int k = NAME_OFS; k < WIN_LEN; k++)
                last_next[k] = (IDX_W'(k) == IDX_W'(NAME_OFS - 1) + IDX_W'(ev.burst))
                            && !ev.sum_valid;
            nq_next = CNT_W'(ev.burst);
            rd_next = IDX_W'(NAME_OFS);
        end
        else if (ev.append)
        begin
            // appended names keep the queue flush with the window tail
            nq_next = nq_reg + CNT_W'(1) - CNT_W'(pop_name);
            rd_next = IDX_W'(WIN_LEN) - IDX_W'(nq_next);
        end
        else if (pop_name)
        begin
            nq_next = nq_reg - CNT_W'(1);
            rd_next = rd_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        sum_pend_next = sum_pend_reg;
        if (ev.sum_valid)
            sum_pend_next = 1'b1;
        else if (pop_sum)
            sum_pend_next = 1'b0;
    end

    assign valid_next = out_load ? (have_name || sum_pend_reg) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nq_reg       <= '0;
            rd_reg       <= '0;
            sum_pend_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            nq_reg       <= nq_next;
            rd_reg       <= rd_next;
            sum_pend_reg <= sum_pend_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        last_reg <= last_next;
        if (ev.sum_valid)
        begin
            sum_kind_reg  <= ev.sum_kind;
            sum_dest_reg  <= ev.sum_dest;
            sum_len_reg   <= ev.sum_len;
            sum_trunc_reg <= ev.sum_trunc;
        end
        if (pop_name)
        begin
            kind_reg     <= KIND_NAME;
            byte_reg     <= name_sel;
            dest_reg     <= '0;
            len_reg      <= '0;
            trunc_reg    <= 1'b0;
            last_out_reg <= last_sel;
        end
        else if (pop_sum)
        begin
            kind_reg     <= sum_kind_reg;
            byte_reg     <= '0;
            dest_reg     <= sum_dest_reg;
            len_reg      <= sum_len_reg;
            trunc_reg    <= sum_trunc_reg;
            last_out_reg <= 1'b1;
        end
    end

    assign result_valid   = valid_reg;
    assign result_kind    = kind_reg;
    assign name_byte      = byte_reg;
    assign dest_address   = dest_reg;
    assign name_length    = len_reg;
    assign name_truncated = trunc_reg;
    assign last_of_run    = last_out_reg;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nq_reg <= CNT_W'(QUEUE_LIMIT))
        else $error("name queue overran the window");
    a_match_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ev.match |-> ((nq_reg == '0) && !sum_pend_reg))
        else $error("window match while names still queued");
    a_append_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (ev.append && (nq_reg != '0))
            |-> (({1'b0, rd_reg} + {1'b0, nq_reg}) == (IDX_W + 1)'(WIN_LEN)))
        else $error("queued names not flush with window tail");
    a_no_shift_on_summary: assert property (@(posedge clk) disable iff (!rst_n)
        sum_pend_reg |-> !ev.shift)
        else $error("window shifted while a summary waits");
`endif

endmodule

@@ hw/rtl/tls_sni_extractor.sv @@
// Top level of the TLS ClientHello server-name extractor.
// Output path: a name byte or summary goes from the name queue or pending summary into
// the result register before it shows on the result port.
// Throughput: one byte per cycle; a frame summary holds the input until it leaves, and
// 20 queued names stall it as well.
// Reset: rst_n clears parse state, the name queue and the result valid flag at once.
module tls_sni_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  name_byte,
    output logic [31:0] dest_address,
    output logic [15:0] name_length,
    output logic        name_truncated,
    output logic        last_of_run
);
    import tsx_pkg::*;

    logic       accept;
    tsx_event_t ev;
    win_taps_t  taps;

    // take a word whenever data_valid is high, the queue has room and no summary is waiting
    assign accept = data_valid && !data_stall;

    // parser: header fields, handshake check, SNI match and summary decision
    tsx_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .taps      (taps),
        .ev        (ev)
    );

    // queue: 21-byte window doubles as the name queue; drains one result per cycle while result_stall is low
    tsx_queue u_queue (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .ev             (ev),
        .taps           (taps),
        .in_stall       (data_stall),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_kind    (result_kind),
        .name_byte      (name_byte),
        .dest_address   (dest_address),
        .name_length    (name_length),
        .name_truncated (name_truncated),
        .last_of_run    (last_of_run)
    );

endmodule

@@ tb/sv/tls_sni_extractor_checker.sv @@
`timescale 1ns / 1ps
// Checker of the TLS SNI extractor: byte-level predictor and result scoreboard.
module tls_sni_extractor_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  result_kind,
    input  logic [7:0]  name_byte,
    input  logic [31:0] dest_address,
    input  logic [15:0] name_length,
    input  logic        name_truncated,
    input  logic        last_of_run,
    output int unsigned fail_count,
    output int unsigned outstanding
);
    import tsx_pkg::*;

    typedef struct {
        result_kind_t kind;
        logic [7:0]   host_byte;
        logic [31:0]  dest;
        logic [15:0]  host_len;
        logic         trunc;
        logic         last;
    } sni_result_t;

    sni_result_t sni_expect_q[$];
    int unsigned results_seen = 0;

    // parse state of the frame in flight
    logic [POS_W-1:0] sni_pos;
    logic [7:0]       sni_win [WIN_LEN];
    logic [5:0]       sni_ip_len;
    logic [5:0]       sni_tcp_len;
    logic [POS_W-1:0] sni_pay_start;
    logic [31:0]      sni_dest;
    phase_t           sni_phase;
    logic [15:0]      sni_name_left;
    logic [15:0]      sni_name_len;

    function automatic void clear_frame();
        sni_pos = '0;
        foreach (sni_win[k])
            sni_win[k] = 8'd0;
        sni_ip_len = '0;
        sni_tcp_len = '0;
        sni_pay_start = '0;
        sni_dest = '0;
        sni_phase = PH_HEADER;
        sni_name_left = '0;
        sni_name_len = '0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t sni_check: result %0d: %s", $time, results_seen, msg);
        fail_count++;
    endtask

    // Advance the parser by one byte and queue the results it releases.
    task automatic predict_sni_word(input logic [7:0] b, input logic fe);
        sni_result_t run[$];
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] off;
        logic [3:0]  ihl;
        logic [5:0]  th;
        logic [16:0] ext_len;
        logic [16:0] list_len;
        logic [16:0] host_len;
        logic [15:0] burst;
        logic        hit;
        if (sni_pos < MAX_FRAME_BYTES) begin
            pos = sni_pos;
            sni_pos = pos + 1'b1;
            if (sni_phase == PH_HEADER) begin
                if (pos == IHL_POS) begin
                    ihl = 4'(b & IHL_MASK);
                    if (ihl < MIN_HDR_WORDS)
                        sni_phase = PH_IGNORE;
                    else
                        sni_ip_len = {ihl, 2'b00};
                end else if (pos >= DEST_FIRST && pos <= DEST_LAST) begin
                    sni_dest = {sni_dest[23:0], b};
                end else if (pos > IHL_POS && pos == DOFF_BASE + sni_ip_len) begin
                    th = 6'((b & DOFF_MASK) >> 2);
                    if (th < MIN_TCP_BYTES) begin
                        sni_phase = PH_IGNORE;
                    end else begin
                        sni_tcp_len = th;
                        sni_pay_start = POS_W'(ETH_HDR_BYTES + sni_ip_len + th);
                    end
                end else if (sni_pay_start != 0 && pos >= sni_pay_start) begin
                    sni_phase = PH_PAYLOAD;
                end
            end

            if (sni_phase == PH_PAYLOAD) begin
                off = pos - sni_pay_start;
                for (int k = 0; k < WIN_LEN - 1; k++)
                    sni_win[k] = sni_win[k + 1];
                sni_win[WIN_LEN - 1] = b;
                ext_len  = {1'b0, sni_win[2], sni_win[3]};
                list_len = {1'b0, sni_win[4], sni_win[5]};
                host_len = {1'b0, sni_win[7], sni_win[8]};
                hit = sni_win[0] == 8'd0 && sni_win[1] == 8'd0 && sni_win[2] <= 8'd1
                    && sni_win[6] == 8'd0 && ext_len == list_len + 17'd2
                    && ext_len == host_len + 17'd5;
                if (off == 0 && b != TLS_HANDSHAKE) begin
                    sni_phase = PH_IGNORE;
                end else if (off == HELLO_OFS && b != TLS_CLIENT_HELLO) begin
                    sni_phase = PH_IGNORE;
                end else if (off >= SCAN_SPAN && hit) begin
                    // names already sitting in the window go out at once
                    burst = host_len[15:0] < NAME_BURST ? host_len[15:0] : 16'(NAME_BURST);
                    for (int k = 0; k < burst; k++)
                        run.push_back('{KIND_NAME, sni_win[NAME_OFS + k], 32'd0, 16'd0,
                                        1'b0, 1'b0});
                    sni_name_len = host_len[15:0];
                    sni_name_left = host_len[15:0] - burst;
                    sni_phase = PH_FOUND;
                end
            end else if (sni_phase == PH_FOUND && sni_name_left != 0) begin
                run.push_back('{KIND_NAME, b, 32'd0, 16'd0, 1'b0, 1'b0});
                sni_name_left--;
            end
        end

        if (fe) begin
            if (sni_phase == PH_PAYLOAD && sni_pos >= MIN_HEADER_BYTES
                && sni_pos - sni_pay_start >= MIN_PAYLOAD_SEEN)
                run.push_back('{KIND_NO_SNI, 8'd0, sni_dest, 16'd0, 1'b0, 1'b0});
            else if (sni_phase == PH_FOUND)
                run.push_back('{KIND_FOUND, 8'd0, sni_dest, sni_name_len,
                                sni_name_left != 0, 1'b0});
            clear_frame();
        end

        if (run.size() != 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[k])
            sni_expect_q.push_back(run[k]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        sni_result_t want;
        if (!rst_n) begin
            clear_frame();
            sni_expect_q.delete();
            outstanding <= 0;
        end else begin
            if (data_valid && !data_stall)
                predict_sni_word(data_byte, frame_end);
            if (result_valid && !result_stall) begin
                if (sni_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, kind %0d", result_kind));
                end else begin
                    want = sni_expect_q.pop_front();
                    if (result_kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  result_kind, want.kind));
                    if (name_byte !== want.host_byte)
                        report_mismatch($sformatf("name_byte %h, want %h",
                                                  name_byte, want.host_byte));
                    if (dest_address !== want.dest)
                        report_mismatch($sformatf("dest_address %h, want %h",
                                                  dest_address, want.dest));
                    if (name_length !== want.host_len)
                        report_mismatch($sformatf("name_length %0d, want %0d",
                                                  name_length, want.host_len));
                    if (name_truncated !== want.trunc)
                        report_mismatch($sformatf("name_truncated %b, want %b",
                                                  name_truncated, want.trunc));
                    if (last_of_run !== want.last)
                        report_mismatch($sformatf("last_of_run %b, want %b",
                                                  last_of_run, want.last));
                end
                results_seen++;
            end
            outstanding <= sni_expect_q.size();
        end
    end

endmodule

@@ tb/sv/tls_sni_extractor_tb.sv @@
`timescale 1ns / 1ps
// Testbench top of the TLS SNI extractor: clock, reset, frame stimulus, watchdog, verdict.
module tls_sni_extractor_tb;
    import tsx_pkg::*;

    localparam int ITEM_BUDGET    = 360;    // bytes offered over the whole run
    localparam int CALM_ITEMS     = 60;     // tail of the run with no idling at all
    localparam int WATCHDOG_LIMIT = 3000;   // cycles without any handshake
    localparam int LONG_HOLD      = 400;    // result side held off to fill the name queue
    localparam int END_DRAIN      = 40;     // trailing cycles to catch stray results
    localparam int HOLD_HOST_LEN  = 24;     // name long enough to back the queue up

    // Shape of one generated Ethernet/IPv4/TCP frame.
    typedef struct {
        int          ihl;          // IP header length in 32-bit words
        int          doff;         // TCP data offset in 32-bit words
        logic [31:0] dest;
        logic [7:0]  rec_type;     // payload byte 0
        logic [7:0]  hello_type;   // payload byte 5
        int          payload_len;
        int          ext_at;       // payload offset of the SNI extension, -1 for none
        int          name_len;
        int          name_fill;    // constant name byte, -1 for random
        int          cut;          // keep only this many bytes, 0 keeps the frame whole
        bit          spoil;        // break the name length so the lengths disagree
        bit          noise;        // overwrite every byte with random data
    } frame_spec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        data_valid = 1'b0;
    logic        data_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        frame_end = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  name_byte;
    logic [31:0] dest_address;
    logic [15:0] name_length;
    logic        name_truncated;
    logic        last_of_run;

    int unsigned fail_count;
    int unsigned outstanding;

    bit calm = 1'b0;            // long hold and final stretch: no random idling on either side
    int rx_hold_cycles = 0;     // request for one long hold on the result side
    int items_sent = 0;         // bytes taken by the block so far

    tls_sni_extractor i_dut (.*);

    tls_sni_extractor_checker i_sni_check (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Typical well-formed ClientHello frame carrying a name of the given length.
    function automatic frame_spec_t hello_spec(input int name_len);
        frame_spec_t s;
        s.ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(MIN_HDR_WORDS + 1, 15)
                                            : MIN_HDR_WORDS;
        s.doff = ($urandom_range(0, 1) == 0) ? $urandom_range(MIN_HDR_WORDS + 1, 15)
                                             : MIN_HDR_WORDS;
        s.dest = $urandom;
        s.rec_type = TLS_HANDSHAKE;
        s.hello_type = TLS_CLIENT_HELLO;
        s.ext_at = $urandom_range(HELLO_OFS + 1, HELLO_OFS + 12);
        s.name_len = name_len;
        s.payload_len = s.ext_at + NAME_OFS + name_len + $urandom_range(0, 8);
        // the match is only seen once the window has filled past the extension
        if (s.payload_len < s.ext_at + SCAN_SPAN + 1)
            s.payload_len = s.ext_at + SCAN_SPAN + 1;
        s.name_fill = -1;
        s.cut = 0;
        s.spoil = 1'b0;
        s.noise = 1'b0;
        return s;
    endfunction

    // Build one frame and push it byte by byte, with random gaps on the valid line.
    task automatic run_frame(input frame_spec_t s);
        logic [7:0]  frame_bytes[$];
        logic [7:0]  ext_hdr [NAME_OFS];
        logic [15:0] host_len;
        logic [15:0] ext_len;
        logic [15:0] list_len;
        int          ip_bytes;
        int          tcp_bytes;
        int          base;
        int          at;
        int          tx_rate;
        ip_bytes = 4 * (s.ihl < MIN_HDR_WORDS ? MIN_HDR_WORDS : s.ihl);
        tcp_bytes = 4 * (s.doff < MIN_HDR_WORDS ? MIN_HDR_WORDS : s.doff);
        repeat (ETH_HDR_BYTES + ip_bytes + tcp_bytes)
            frame_bytes.push_back(8'($urandom));
        frame_bytes[IHL_POS] = {4'h4, 4'(s.ihl)};
        for (int k = 0; k < 4; k++)
            frame_bytes[DEST_FIRST + k] = s.dest[31 - 8 * k -: 8];
        frame_bytes[DOFF_BASE + ip_bytes] = {4'(s.doff), 4'($urandom)};

        base = frame_bytes.size();
        repeat (s.payload_len)
            frame_bytes.push_back(8'($urandom));
        if (s.payload_len > 0)
            frame_bytes[base] = s.rec_type;
        if (s.payload_len > HELLO_OFS)
            frame_bytes[base + HELLO_OFS] = s.hello_type;

        // server-name extension: type, extension length, list length, name type,
        // name length, then the name itself
        if (s.ext_at >= 0) begin
            host_len = 16'(s.name_len);
            ext_len = host_len + 16'd5;
            list_len = host_len + 16'd3;
            ext_hdr = '{8'h00, 8'h00, ext_len[15:8], ext_len[7:0], list_len[15:8],
                        list_len[7:0], 8'h00, host_len[15:8], host_len[7:0]};
            if (s.spoil)
                ext_hdr[NAME_OFS - 1] ^= 8'h01;
            for (int k = 0; k < NAME_OFS + s.name_len; k++) begin
                at = base + s.ext_at + k;
                if (at < frame_bytes.size()) begin
                    if (k < NAME_OFS)
                        frame_bytes[at] = ext_hdr[k];
                    else if (s.name_fill >= 0)
                        frame_bytes[at] = 8'(s.name_fill);
                end
            end
        end

        while (s.cut > 0 && frame_bytes.size() > s.cut)
            void'(frame_bytes.pop_back());
        if (s.noise)
            foreach (frame_bytes[k])
                frame_bytes[k] = 8'($urandom);

        case ($urandom_range(0, 2))
            0: tx_rate = 0;
            1: tx_rate = 12;
            default: tx_rate = 3;
        endcase
        if (calm)
            tx_rate = 0;

        foreach (frame_bytes[k]) begin
            // drop valid for a burst now and then, at any point of the frame
            if (tx_rate != 0 && $urandom_range(1, tx_rate) == 1) begin
                data_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            data_valid <= 1'b1;
            data_byte <= frame_bytes[k];
            frame_end <= (k == frame_bytes.size() - 1);
            // hold the word until it is taken
            do @(posedge clk); while (data_stall);
            items_sent++;
        end
    endtask

    // Stop offering words until every predicted result has come out.
    task automatic drain_results();
        data_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Result side: random stall bursts in stretches of varying density, plus one
    // long hold on request.
    initial
    begin : result_side
        int rx_rate;
        int stretch;
        rx_rate = 0;
        stretch = 0;
        @(posedge clk);
        forever begin
            if (stretch == 0) begin
                stretch = $urandom_range(64, 512);
                case ($urandom_range(0, 2))
                    0: rx_rate = 0;
                    1: rx_rate = 8;
                    default: rx_rate = 2;
                endcase
            end
            stretch--;
            if (rx_hold_cycles != 0) begin
                result_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                result_stall <= 1'b0;
                @(posedge clk);
            end else if (!calm && rx_rate != 0 && $urandom_range(1, rx_rate) == 1) begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                result_stall <= 1'b0;
                @(posedge clk);
            end else begin
                @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((data_valid && !data_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : frame_source
        frame_spec_t s;
        int          roll;
        int          host_len;
        int          frame_len;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single byte carrying frame_end: nothing comes out
        s = hello_spec(8);
        s.cut = 1;
        run_frame(s);
        // frame ends on the matching byte: a full burst of names plus the summary
        s = hello_spec(NAME_BURST);
        s.ihl = MIN_HDR_WORDS;
        s.doff = MIN_HDR_WORDS;
        s.ext_at = HELLO_OFS + 1;
        s.dest = '1;
        s.payload_len = s.ext_at + SCAN_SPAN + 1;
        run_frame(s);
        // name well past the burst; hold results so the name queue fills and the
        // input stalls while the bytes keep coming
        s = hello_spec(HOLD_HOST_LEN);
        s.ihl = MIN_HDR_WORDS;
        s.doff = MIN_HDR_WORDS;
        s.ext_at = HELLO_OFS + 1;
        s.payload_len = s.ext_at + NAME_OFS + HOLD_HOST_LEN;
        calm = 1'b1;
        rx_hold_cycles = LONG_HOLD;
        run_frame(s);
        calm = 1'b0;

        // let the pipeline run dry before the random part
        drain_results();

        while (items_sent < ITEM_BUDGET) begin
            calm = (items_sent >= ITEM_BUDGET - CALM_ITEMS);
            case ($urandom_range(0, 9))
                0: host_len = $urandom_range(25, 60);
                default: host_len = $urandom_range(0, 24);
            endcase
            s = hello_spec(host_len);
            frame_len = ETH_HDR_BYTES + 4 * s.ihl + 4 * s.doff + s.payload_len;
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                // well-formed, name complete
            end else if (roll < 72) begin
                s.cut = $urandom_range(1, frame_len);
            end else if (roll < 78) begin
                s.ext_at = -1;
                s.payload_len = $urandom_range(0, SCAN_SPAN);
            end else if (roll < 84) begin
                if ($urandom_range(0, 1) == 0)
                    s.rec_type = TLS_HANDSHAKE ^ 8'($urandom_range(1, 255));
                else
                    s.hello_type = TLS_CLIENT_HELLO ^ 8'($urandom_range(1, 255));
            end else if (roll < 90) begin
                if ($urandom_range(0, 1) == 0)
                    s.ihl = $urandom_range(0, MIN_HDR_WORDS - 1);
                else
                    s.doff = $urandom_range(0, MIN_HDR_WORDS - 1);
            end else if (roll < 95) begin
                // short name released in one burst as the frame ends, unless the length is spoiled
                s.name_len = $urandom_range(0, NAME_BURST);
                s.payload_len = s.ext_at + SCAN_SPAN + 1;
                s.spoil = ($urandom_range(0, 3) == 0);
            end else begin
                s.noise = 1'b1;
                s.cut = $urandom_range(1, 150);
            end
            run_frame(s);
        end

        drain_results();
        repeat (END_DRAIN) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
